/* hdl/fpc_pkg.sv */
`default_nettype none
package fpc_pkg;

    typedef enum logic [1:0] {
        RSN_PASS       = 2'd0,
        RSN_SMALL_EVEN = 2'd1,
        RSN_SHARED     = 2'd2,
        RSN_FERMAT     = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        MM_REDUCE = 2'd0,
        MM_SQUARE = 2'd1,
        MM_MULT   = 2'd2
    } t_mm_sel;

    typedef struct packed {
        logic    load;
        logic    gcd_start;
        logic    gcd_step;
        logic    mm_start;
        t_mm_sel mm_sel;
        logic    acc_init;
        logic    take_b;
        logic    take_acc;
        logic    exp_shift;
    } t_dp_cmd;

    typedef struct packed {
        logic n_bad;
        logic gcd_zero;
        logic gcd_one;
        logic mm_busy;
        logic exp_bit;
        logic acc_one;
    } t_dp_sts;

endpackage
`default_nettype wire

/* hdl/fpc_if.sv */
`default_nettype none
interface fpc_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] number;
    logic [30:0] witness;
    logic        last_round;

    modport source (output valid, number, witness, last_round, input ready);
    modport sink   (input valid, number, witness, last_round, output ready);
endinterface

interface fpc_out_if;
    logic       valid;
    logic       ready;
    logic       probable_prime;
    logic [1:0] verdict_reason;

    modport source (output valid, probable_prime, verdict_reason, input ready);
    modport sink   (input valid, probable_prime, verdict_reason, output ready);
endinterface
`default_nettype wire

/* hdl/fpc_datapath.sv */
`default_nettype none
module fpc_datapath
    import fpc_pkg::*;
#(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [30:0] i_number,
    input  wire logic [30:0] i_witness,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts
);
    localparam int W  = NUM_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]  r_n, r_a, r_e, r_acc, r_b;
    logic [W-1:0]  r_gx, r_gy;
    logic [W-1:0]  r_mx, r_my, r_macc;
    logic [CW-1:0] r_mcnt;
    logic          r_mph;
    logic          r_mbusy;

    // (x + y) mod m for x, y < m
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                             input logic [W-1:0] y,
                                             input logic [W-1:0] m);
        logic [W-1:0] room;
        room = m - y;
        return (x >= room) ? (x - room) : (x + y);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= W'(i_number);
            r_a <= W'(i_witness);
            r_e <= W'(i_number) - W'(1);
        end else if (i_cmd.exp_shift) begin
            r_e <= {r_e[W-2:0], 1'b0};
        end

        if (i_cmd.gcd_start) begin
            r_gx <= r_a;
            r_gy <= r_n;
        end else if (i_cmd.gcd_step && (r_gx != '0)) begin
            if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gx;
                r_gx <= r_gy - r_gx;
            end
        end

        if (i_cmd.acc_init) begin
            r_acc <= W'(1);
        end else if (i_cmd.take_acc) begin
            r_acc <= r_macc;
        end
        if (i_cmd.take_b) begin
            r_b <= r_macc;
        end

        // modular multiply: double then conditional add, one half-step a cycle
        if (i_cmd.mm_start) begin
            case (i_cmd.mm_sel)
                MM_REDUCE: begin
                    r_mx <= W'(1);
                    r_my <= r_a;
                end
                MM_SQUARE: begin
                    r_mx <= r_acc;
                    r_my <= r_acc;
                end
                default: begin
                    r_mx <= r_b;
                    r_my <= r_acc;
                end
            endcase
            r_macc <= '0;
            r_mcnt <= CW'(W - 1);
            r_mph  <= 1'b0;
        end else if (r_mbusy) begin
            if (!r_mph) begin
                r_macc <= add_mod(r_macc, r_macc, r_n);
                if (r_my[W-1]) begin
                    r_mph <= 1'b1;
                end else begin
                    r_my   <= {r_my[W-2:0], 1'b0};
                    r_mcnt <= r_mcnt - CW'(1);
                end
            end else begin
                r_macc <= add_mod(r_macc, r_mx, r_n);
                r_my   <= {r_my[W-2:0], 1'b0};
                r_mcnt <= r_mcnt - CW'(1);
                r_mph  <= 1'b0;
            end
        end

        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_cmd.mm_start) begin
            r_mbusy <= 1'b1;
        end else if (r_mbusy && (r_mcnt == '0) && (r_mph || !r_my[W-1])) begin
            r_mbusy <= 1'b0;
        end
    end

    assign o_sts.n_bad    = !r_n[0] || (r_n == W'(1));
    assign o_sts.gcd_zero = (r_gx == '0);
    assign o_sts.gcd_one  = (r_gy == W'(1));
    assign o_sts.mm_busy  = r_mbusy;
    assign o_sts.exp_bit  = r_e[W-1];
    assign o_sts.acc_one  = (r_acc == W'(1));

endmodule
`default_nettype wire

/* hdl/fpc_controller.sv */
`default_nettype none
module fpc_controller
    import fpc_pkg::*;
#(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_last_round,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output logic      o_probable_prime,
    output logic [1:0] o_verdict_reason,
    output t_dp_cmd   o_cmd,
    input  wire t_dp_sts i_sts
);
    localparam int CW = $clog2(NUM_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_GCD, S_REDUCE, S_WAIT_B, S_SQ, S_WAIT_SQ,
        S_MUL, S_WAIT_MUL, S_NEXT, S_FINAL, S_FINISH
    } t_state;

    t_state        r_state;
    t_reason       r_verdict;
    logic          r_last;
    logic [CW-1:0] r_cnt;
    logic          r_ov;
    logic          accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.mm_sel    = MM_REDUCE;
        o_cmd.load      = accept;
        case (r_state)
            S_CHECK:    o_cmd.gcd_start = (r_verdict == RSN_PASS) && !i_sts.n_bad;
            S_GCD:      o_cmd.gcd_step  = 1'b1;
            S_REDUCE:   o_cmd.mm_start  = 1'b1;
            S_WAIT_B: begin
                o_cmd.take_b   = !i_sts.mm_busy;
                o_cmd.acc_init = !i_sts.mm_busy;
            end
            S_SQ: begin
                o_cmd.mm_start = 1'b1;
                o_cmd.mm_sel   = MM_SQUARE;
            end
            S_WAIT_SQ:  o_cmd.take_acc = !i_sts.mm_busy;
            S_MUL: begin
                o_cmd.mm_start = 1'b1;
                o_cmd.mm_sel   = MM_MULT;
            end
            S_WAIT_MUL: o_cmd.take_acc  = !i_sts.mm_busy;
            S_NEXT:     o_cmd.exp_shift = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_verdict <= RSN_PASS;
            r_ov      <= 1'b0;
            r_last    <= 1'b0;
            r_cnt     <= '0;
            o_probable_prime <= 1'b0;
            o_verdict_reason <= '0;
        end else begin
            // load a new verdict, else drop the one just taken
            if ((r_state == S_FINISH) && r_last && (!r_ov || i_out_ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last  <= i_last_round;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_verdict != RSN_PASS) begin
                        r_state <= S_FINISH;
                    end else if (i_sts.n_bad) begin
                        r_verdict <= RSN_SMALL_EVEN;
                        r_state   <= S_FINISH;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (i_sts.gcd_zero) begin
                        if (i_sts.gcd_one) begin
                            r_state <= S_REDUCE;
                        end else begin
                            r_verdict <= RSN_SHARED;
                            r_state   <= S_FINISH;
                        end
                    end
                end
                S_REDUCE: r_state <= S_WAIT_B;
                S_WAIT_B: begin
                    if (!i_sts.mm_busy) begin
                        r_cnt   <= CW'(NUM_WIDTH - 1);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: r_state <= S_WAIT_SQ;
                S_WAIT_SQ: begin
                    if (!i_sts.mm_busy) begin
                        r_state <= i_sts.exp_bit ? S_MUL : S_NEXT;
                    end
                end
                S_MUL: r_state <= S_WAIT_MUL;
                S_WAIT_MUL: begin
                    if (!i_sts.mm_busy) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_SQ;
                    end
                end
                S_FINAL: begin
                    if (!i_sts.acc_one) begin
                        r_verdict <= RSN_FERMAT;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (!r_ov || i_out_ready) begin
                        o_probable_prime <= (r_verdict == RSN_PASS);
                        o_verdict_reason <= r_verdict;
                        r_verdict        <= RSN_PASS;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;

endmodule
`default_nettype wire

/* hdl/fermat_primality_check_core.sv */
`default_nettype none
// Fermat primality check. Each input item brings a candidate number, one
// witness and a last-round mark; the core keeps the verdict of the current
// run (the first failing round wins) and sends one result item, carrying
// probable_prime and verdict_reason, after the item marked as last round.
// Numbers below 3 and even numbers fail as too small or even; a witness
// sharing a factor with the number fails as shared factor; otherwise the
// core needs witness^(number-1) mod number to equal 1. Items are taken one
// at a time. An item that arrives after a failure in its run goes straight
// to the result, as does a too-small or even number. A full round runs a
// binary GCD, then (NUM_WIDTH+1) modular multiplications and up to
// NUM_WIDTH more for set exponent bits, each multiplication doubling once
// per multiplier bit and adding once per set multiplier bit. A single
// double-and-add modular multiplier serves the reduction, the squarings
// and the multiplications. A finished result waits in an output register
// while the next item is taken in.
module fermat_primality_check_core
    import fpc_pkg::*;
#(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpc_in_if.sink    i_in,
    fpc_out_if.source o_out
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequence the rounds, hold the run verdict and the output register
    fpc_controller #(
        .NUM_WIDTH(NUM_WIDTH)
    ) u_ctl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .i_last_round    (i_in.last_round),
        .o_in_ready      (i_in.ready),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_probable_prime(o_out.probable_prime),
        .o_verdict_reason(o_out.verdict_reason),
        .o_cmd           (cmd),
        .i_sts           (sts)
    );

    // operand registers, binary GCD and the modular multiplier
    fpc_datapath #(
        .NUM_WIDTH(NUM_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_number (i_in.number),
        .i_witness(i_in.witness),
        .i_cmd    (cmd),
        .o_sts    (sts)
    );

endmodule
`default_nettype wire
